FILE: rtl/trap_pkg.sv
// Shared types and constants for the trapezoidal motion profile block.
`default_nettype none

package trap_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_TARGET = 2'd0;
    localparam logic [1:0] REG_RATE   = 2'd1;
    localparam logic [1:0] REG_ACCEL  = 2'd2;

    // Phase codes
    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_ACCEL = 3'd1;
    localparam logic [2:0] PH_CRUISE = 3'd2;
    localparam logic [2:0] PH_DECEL = 3'd3;
    localparam logic [2:0] PH_DONE  = 3'd4;

    // Step counts of the shared arithmetic unit
    localparam logic [6:0] MUL_STEPS  = 7'd4;
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    localparam logic [23:0] MAX24 = 24'hFF_FFFF;
    localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WW,
        ST_DA,
        ST_TRI_DIV,
        ST_TRI_SQRT,
        ST_TRI_PEAK,
        ST_TRAP_DIV,
        ST_TRAP_AW,
        ST_TRAP_CRUISE,
        ST_EV_CMP,
        ST_EV_MUL1,
        ST_EV_MUL2,
        ST_EV_MUL3,
        ST_EV_OUT
    } state_t;

endpackage

`default_nettype wire

FILE: rtl/trapezoidal_motion_profile.sv
// Trapezoidal motion profile: plan sequencer, shared mul/div/sqrt unit, evaluator.
// With a cached plan a request runs the compare, multiply and output states (a third multiply
//   when cruising, none outside the move); the first request after reset or a register write
//   also runs the planning states, on the 64-step divider and (triangular) 32-step square root.
// A new request is accepted only while idle (busy low); the receiver cannot stall,
//   done is high for one cycle. Reset clears the sequencer, plan flag, regs to 0, 1, 1.
`default_nettype none

module trapezoidal_motion_profile
    import trap_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [31:0] sample_time,
    output logic                    done,
    output logic signed [24:0]      rate,
    output logic signed [23:0]      angle,
    output logic [2:0]              phase,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [23:0]        cfg_data
);

    // Configuration and plan state
    state_t        state_reg, state_next;
    logic [23:0]   tgt_reg, wl_reg, al_reg;
    logic          plan_ok_reg;
    logic [47:0]   ww_reg, da_reg;
    logic [31:0]   ta_reg, tc_reg;
    logic [33:0]   tot_reg;
    logic [23:0]   peak_reg;

    // Request state
    logic [31:0]   t_reg;
    logic [2:0]    ph_reg;
    logic [33:0]   u_reg;
    logic [30:0]   dlt_reg;
    logic [23:0]   rmag_reg;
    logic [63:0]   ang_reg;

    // Shared unit
    logic [6:0]    cnt_reg;
    logic [127:0]  prod_reg;
    logic [63:0]   mx_reg, nsh_reg, quo_reg;
    logic [65:0]   rem_reg;

    logic          done_reg;
    logic [24:0]   rate_reg;
    logic [23:0]   angle_reg;
    logic [2:0]    phase_reg;

    // Derived operands
    logic [23:0]   w_eff, a_eff, dmag;
    logic          neg;
    assign w_eff = (wl_reg == 24'd0) ? 24'd1 : wl_reg;
    assign a_eff = (al_reg == 24'd0) ? 24'd1 : al_reg;
    assign neg   = tgt_reg[23];
    assign dmag  = neg ? (24'd0 - tgt_reg) : tgt_reg;

    // Operation and operands for the current state
    op_t           op;
    logic [63:0]   ld_a, ld_b;
    logic [6:0]    steps;
    logic          unit_state;
    always_comb
    begin
        op         = OP_MUL;
        ld_a       = 64'd0;
        ld_b       = 64'd0;
        unit_state = 1'b1;
        case (state_reg)
            ST_WW:
            begin
                ld_a = {40'd0, w_eff};
                ld_b = {40'd0, w_eff};
            end
            ST_DA:
            begin
                ld_a = {40'd0, dmag};
                ld_b = {40'd0, a_eff};
            end
            ST_TRI_DIV:
            begin
                op   = OP_DIV;
                ld_a = {40'd0, a_eff};
                ld_b = {8'd0, dmag, 32'd0};
            end
            ST_TRI_SQRT:
            begin
                op   = OP_SQRT;
                ld_b = quo_reg;
            end
            ST_TRI_PEAK:
            begin
                ld_a = {40'd0, a_eff};
                ld_b = {32'd0, ta_reg};
            end
            ST_TRAP_DIV:
            begin
                op   = OP_DIV;
                ld_a = {40'd0, a_eff};
                ld_b = {24'd0, w_eff, 16'd0};
            end
            ST_TRAP_AW:
            begin
                ld_a = {40'd0, a_eff};
                ld_b = {40'd0, w_eff};
            end
            ST_TRAP_CRUISE:
            begin
                op   = OP_DIV;
                ld_a = {16'd0, prod_reg[47:0]};
                ld_b = {(da_reg - ww_reg), 16'd0};
            end
            ST_EV_MUL1:
            begin
                ld_a = {40'd0, a_eff};
                ld_b = {30'd0, u_reg};
            end
            ST_EV_MUL2:
            begin
                ld_a = prod_reg[63:0];
                ld_b = {30'd0, u_reg};
            end
            ST_EV_MUL3:
            begin
                ld_a = {40'd0, peak_reg};
                ld_b = {33'd0, dlt_reg};
            end
            default:
            begin
                unit_state = 1'b0;
            end
        endcase
        case (op)
            OP_MUL:  steps = MUL_STEPS;
            OP_DIV:  steps = DIV_STEPS;
            OP_SQRT: steps = SQRT_STEPS;
            default: steps = MUL_STEPS;
        endcase
    end

    logic unit_done;
    assign unit_done = unit_state && (cnt_reg == steps + 7'd1);

    // One step of the shared unit: multiply-accumulate or compare-subtract
    logic [79:0]   mac_sum;
    logic [65:0]   shv, trial;
    logic [66:0]   diff;
    logic          ge;
    always_comb
    begin
        mac_sum = {16'd0, prod_reg[127:64]} + (mx_reg * {64'd0, prod_reg[15:0]});
        if (op == OP_SQRT)
        begin
            shv   = {rem_reg[63:0], nsh_reg[63:62]};
            trial = {quo_reg, 2'b01};
        end
        else
        begin
            shv   = {rem_reg[64:0], nsh_reg[63]};
            trial = {2'd0, mx_reg};
        end
        diff = {1'b0, shv} - {1'b0, trial};
        ge   = !diff[66];
    end

    // Request evaluation: sample time and end of cruise for the phase choice
    logic [30:0]   tt;
    logic [32:0]   tac;
    always_comb
    begin
        tt  = t_reg[30:0];
        tac = {1'b0, ta_reg} + {1'b0, tc_reg};
    end

    // Final magnitudes
    logic [63:0]   ang_mag;
    logic [23:0]   ang_fin, rate_mag;
    always_comb
    begin
        case (ph_reg)
            PH_ACCEL, PH_CRUISE: ang_mag = ang_reg;
            PH_DECEL: ang_mag = (ang_reg > {40'd0, dmag}) ? 64'd0 : ({40'd0, dmag} - ang_reg);
            PH_DONE:  ang_mag = {40'd0, dmag};
            default:  ang_mag = 64'd0;
        endcase
        ang_fin = (ang_mag > {40'd0, dmag}) ? dmag : ang_mag[23:0];
        case (ph_reg)
            PH_ACCEL, PH_DECEL: rate_mag = rmag_reg;
            PH_CRUISE:          rate_mag = peak_reg;
            default:            rate_mag = 24'd0;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = plan_ok_reg ? ST_EV_CMP : ST_WW;
            ST_WW:
                if (unit_done)
                    state_next = ST_DA;
            ST_DA:
                if (unit_done)
                    state_next = (ww_reg >= prod_reg[47:0]) ? ST_TRI_DIV : ST_TRAP_DIV;
            ST_TRI_DIV:
                if (unit_done)
                    state_next = ST_TRI_SQRT;
            ST_TRI_SQRT:
                if (unit_done)
                    state_next = ST_TRI_PEAK;
            ST_TRI_PEAK:
                if (unit_done)
                    state_next = ST_EV_CMP;
            ST_TRAP_DIV:
                if (unit_done)
                    state_next = ST_TRAP_AW;
            ST_TRAP_AW:
                if (unit_done)
                    state_next = ST_TRAP_CRUISE;
            ST_TRAP_CRUISE:
                if (unit_done)
                    state_next = ST_EV_CMP;
            ST_EV_CMP:
                if (t_reg[31] || ({3'd0, tt} >= tot_reg && {2'd0, tt} >= tac))
                    state_next = ST_EV_OUT;
                else
                    state_next = ST_EV_MUL1;
            ST_EV_MUL1:
                if (unit_done)
                    state_next = ST_EV_MUL2;
            ST_EV_MUL2:
                if (unit_done)
                    state_next = (ph_reg == PH_CRUISE) ? ST_EV_MUL3 : ST_EV_OUT;
            ST_EV_MUL3:
                if (unit_done)
                    state_next = ST_EV_OUT;
            ST_EV_OUT:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        busy      = (state_reg != ST_IDLE);
        cfg_ready = (state_reg == ST_IDLE);
        done      = done_reg;
        rate      = rate_reg;
        angle     = angle_reg;
        phase     = phase_reg;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= 7'd0;
            plan_ok_reg <= 1'b0;
            done_reg    <= 1'b0;
            tgt_reg     <= 24'd0;
            wl_reg      <= 24'd1;
            al_reg      <= 24'd1;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_EV_OUT);
            if (!unit_state || unit_done)
                cnt_reg <= 7'd0;
            else
                cnt_reg <= cnt_reg + 7'd1;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TARGET:
                    begin
                        tgt_reg     <= cfg_data;
                        plan_ok_reg <= 1'b0;
                    end
                    REG_RATE:
                    begin
                        wl_reg      <= cfg_data;
                        plan_ok_reg <= 1'b0;
                    end
                    REG_ACCEL:
                    begin
                        al_reg      <= cfg_data;
                        plan_ok_reg <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if ((state_reg == ST_TRI_PEAK || state_reg == ST_TRAP_CRUISE) && unit_done)
                plan_ok_reg <= 1'b1;
        end
    end

    // Shared unit datapath
    always_ff @(posedge clk)
    begin
        if (unit_state && cnt_reg == 7'd0)
        begin
            mx_reg   <= ld_a;
            nsh_reg  <= ld_b;
            prod_reg <= {64'd0, ld_b};
            rem_reg  <= 66'd0;
            quo_reg  <= 64'd0;
        end
        else if (unit_state && cnt_reg <= steps)
        begin
            if (op == OP_MUL)
                prod_reg <= {mac_sum, prod_reg[63:16]};
            else
            begin
                rem_reg <= ge ? diff[65:0] : shv;
                quo_reg <= {quo_reg[62:0], ge};
                nsh_reg <= (op == OP_SQRT) ? {nsh_reg[61:0], 2'b00} : {nsh_reg[62:0], 1'b0};
            end
        end
    end

    // Plan and request payload registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
            t_reg <= sample_time;
        if (unit_done)
        begin
            case (state_reg)
                ST_WW:
                    ww_reg <= prod_reg[47:0];
                ST_DA:
                    da_reg <= prod_reg[47:0];
                ST_TRI_SQRT:
                    ta_reg <= (quo_reg[63:32] != 32'd0) ? MAX32 : quo_reg[31:0];
                ST_TRI_PEAK:
                begin
                    peak_reg <= (prod_reg[127:40] != 88'd0) ? MAX24 : prod_reg[39:16];
                    tc_reg   <= 32'd0;
                    tot_reg  <= {1'b0, ta_reg, 1'b0};
                end
                ST_TRAP_DIV:
                    ta_reg <= (quo_reg[63:32] != 32'd0) ? MAX32 : quo_reg[31:0];
                ST_TRAP_CRUISE:
                begin
                    peak_reg <= w_eff;
                    tc_reg   <= (quo_reg[63:32] != 32'd0) ? MAX32 : quo_reg[31:0];
                    tot_reg  <= {1'b0, ta_reg, 1'b0} +
                                {2'd0, ((quo_reg[63:32] != 32'd0) ? MAX32 : quo_reg[31:0])};
                end
                ST_EV_MUL1:
                    rmag_reg <= (prod_reg[127:40] != 88'd0) ? MAX24 : prod_reg[39:16];
                ST_EV_MUL2:
                    ang_reg <= prod_reg[96:33];
                ST_EV_MUL3:
                    ang_reg <= ang_reg + prod_reg[79:16];
                default:
                begin
                end
            endcase
        end
        // Phase decision and multiplier operand
        if (state_reg == ST_EV_CMP)
        begin
            dlt_reg <= tt - ta_reg[30:0];
            if (t_reg[31])
            begin
                ph_reg <= PH_IDLE;
                u_reg  <= 34'd0;
            end
            else if ({1'b0, tt} < ta_reg)
            begin
                ph_reg <= PH_ACCEL;
                u_reg  <= {3'd0, tt};
            end
            else if ({2'd0, tt} < tac)
            begin
                ph_reg <= PH_CRUISE;
                u_reg  <= {2'd0, ta_reg};
            end
            else if ({3'd0, tt} < tot_reg)
            begin
                ph_reg <= PH_DECEL;
                u_reg  <= tot_reg - {3'd0, tt};
            end
            else
            begin
                ph_reg <= PH_DONE;
                u_reg  <= 34'd0;
            end
        end
        // Result registers
        if (state_reg == ST_EV_OUT)
        begin
            phase_reg <= ph_reg;
            rate_reg  <= neg ? (25'd0 - {1'b0, rate_mag}) : {1'b0, rate_mag};
            angle_reg <= neg ? (24'd0 - ang_fin) : ang_fin;
        end
    end

    // Checks
    a_done_after_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EV_OUT))
        else $error("result strobe without evaluation");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (phase <= PH_DONE))
        else $error("phase code out of range");
    a_pre_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && phase == PH_IDLE) |-> (rate == 25'sd0 && angle == 24'sd0))
        else $error("non-zero result before start");

endmodule

`default_nettype wire
